/* design/path_command_to_segments_assert.svh */
// assertion macros for the path command block
// used by path_command_to_segments.sv, no other dependencies
`ifndef PATH_COMMAND_TO_SEGMENTS_ASSERT_SVH
`define PATH_COMMAND_TO_SEGMENTS_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PSG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("path segment check failed");
// next-cycle implication
`define PSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("path segment check failed");
`else
`define PSG_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PSG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/psg_pkg.sv */
// shared types and codes for the path command block
// no dependencies
`default_nettype none
package psg_pkg;

	localparam int unsigned COORD_WIDTH_DEF = 32;
	localparam int unsigned FIELD_W = 32;

	typedef enum logic [3:0] {
		CMD_MOVE   = 4'd0,
		CMD_LINE   = 4'd1,
		CMD_HORIZ  = 4'd2,
		CMD_VERT   = 4'd3,
		CMD_QUAD   = 4'd4,
		CMD_CUBIC  = 4'd5,
		CMD_SQUAD  = 4'd6,
		CMD_SCUBIC = 4'd7,
		CMD_CLOSE  = 4'd8
	} cmd_code_t;

	typedef enum logic [2:0] {
		SEG_MOVE  = 3'd0,
		SEG_LINE  = 3'd1,
		SEG_QUAD  = 3'd2,
		SEG_CUBIC = 3'd3,
		SEG_CLOSE = 3'd4
	} seg_code_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_QUAD  = 2'd1,
		KIND_CUBIC = 2'd2
	} curve_kind_t;

	typedef struct packed {
		logic [3:0]                 cmd;
		logic                       relative;
		logic                       first_group;
		logic                       last_group;
		logic                       discard;
		logic signed [FIELD_W-1:0]  ax;
		logic signed [FIELD_W-1:0]  ay;
		logic signed [FIELD_W-1:0]  bx;
		logic signed [FIELD_W-1:0]  by;
		logic signed [FIELD_W-1:0]  cx;
		logic signed [FIELD_W-1:0]  cy;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0]                 seg_kind;
		logic signed [FIELD_W-1:0]  p1x;
		logic signed [FIELD_W-1:0]  p1y;
		logic signed [FIELD_W-1:0]  p2x;
		logic signed [FIELD_W-1:0]  p2y;
		logic signed [FIELD_W-1:0]  p3x;
		logic signed [FIELD_W-1:0]  p3y;
	} seg_item_t;

	typedef struct packed {
		logic      emit;
		seg_item_t seg;
	} exec_res_t;

endpackage
`default_nettype wire

/* design/psg_cmd_if.sv */
// command channel: valid/ready plus one coordinate group
// no dependencies
`default_nettype none
interface psg_cmd_if;
	logic               valid;
	logic               ready;
	logic [3:0]         cmd;
	logic               relative;
	logic               first_group;
	logic               last_group;
	logic               discard;
	logic signed [31:0] ax;
	logic signed [31:0] ay;
	logic signed [31:0] bx;
	logic signed [31:0] by;
	logic signed [31:0] cx;
	logic signed [31:0] cy;

	modport source (output valid, cmd, relative, first_group, last_group, discard,
		ax, ay, bx, by, cx, cy, input ready);
	modport sink (input valid, cmd, relative, first_group, last_group, discard,
		ax, ay, bx, by, cx, cy, output ready);
endinterface
`default_nettype wire

/* design/psg_seg_if.sv */
// segment channel: valid/ready plus one absolute segment
// no dependencies
`default_nettype none
interface psg_seg_if;
	logic               valid;
	logic               ready;
	logic [2:0]         seg_kind;
	logic signed [31:0] p1x;
	logic signed [31:0] p1y;
	logic signed [31:0] p2x;
	logic signed [31:0] p2y;
	logic signed [31:0] p3x;
	logic signed [31:0] p3y;

	modport source (output valid, seg_kind, p1x, p1y, p2x, p2y, p3x, p3y, input ready);
	modport sink (input valid, seg_kind, p1x, p1y, p2x, p2y, p3x, p3y, output ready);
endinterface
`default_nettype wire

/* design/psg_in_reg.sv */
// input register stage for command items
// depends on psg_pkg and psg_cmd_if
`default_nettype none
module psg_in_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	psg_cmd_if.sink             path,
	input  wire logic           take,
	output logic                valid_s1,
	output psg_pkg::cmd_item_t  item_s1
);
	import psg_pkg::*;

	// a slot frees up in the same cycle the held item moves on
	assign path.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (path.ready) begin
			valid_s1 <= path.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (path.ready && path.valid) begin
			item_s1.cmd         <= path.cmd;
			item_s1.relative    <= path.relative;
			item_s1.first_group <= path.first_group;
			item_s1.last_group  <= path.last_group;
			item_s1.discard     <= path.discard;
			item_s1.ax          <= path.ax;
			item_s1.ay          <= path.ay;
			item_s1.bx          <= path.bx;
			item_s1.by          <= path.by;
			item_s1.cx          <= path.cx;
			item_s1.cy          <= path.cy;
		end
	end
endmodule
`default_nettype wire

/* design/psg_exec.sv */
// path state registers and the per-group segment computation
// depends on psg_pkg
`default_nettype none
module psg_exec #(
	parameter int unsigned COORD_WIDTH = psg_pkg::COORD_WIDTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  psg_pkg::cmd_item_t  item,
	output psg_pkg::exec_res_t  res
);
	import psg_pkg::*;

	localparam int unsigned W  = COORD_WIDTH;
	localparam int unsigned EW = (W > FIELD_W) ? W : FIELD_W;
	localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	typedef logic signed [W-1:0] coord_t;

	// clamp a port value into the internal coordinate range
	function automatic coord_t clamp_in(input logic signed [FIELD_W-1:0] v);
		logic signed [EW:0] e;
		e = (EW+1)'(v);
		if (e[EW:W-1] != {(EW-W+2){e[W-1]}}) begin
			return e[EW] ? VMIN : VMAX;
		end
		return e[W-1:0];
	endfunction

	function automatic logic signed [FIELD_W-1:0] to_port(input coord_t v);
		logic signed [EW-1:0] e;
		e = EW'(v);
		return e[FIELD_W-1:0];
	endfunction

	function automatic coord_t sat_add(input coord_t a, input coord_t b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) begin
			return s[W] ? VMIN : VMAX;
		end
		return s[W-1:0];
	endfunction

	function automatic coord_t sat_sub(input coord_t a, input coord_t b);
		logic [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) begin
			return s[W] ? VMIN : VMAX;
		end
		return s[W-1:0];
	endfunction

	coord_t      cur_x_q, cur_y_q, start_x_q, start_y_q, ctrl_x_q, ctrl_y_q, axis_q;
	curve_kind_t last_kind_q;

	coord_t      n_cur_x, n_cur_y, n_start_x, n_start_y, n_ctrl_x, n_ctrl_y, n_axis;
	curve_kind_t n_last_kind;

	coord_t ax_c, ay_c, bx_c, by_c, cx_c, cy_c;
	coord_t ra_x, ra_y, rb_x, rb_y, rc_x, rc_y;
	coord_t rf_x, rf_y, acc_new, h_x, v_y;
	coord_t p0, p1, p2, p3, p4, p5;
	seg_code_t kind;
	logic      emit;

	assign ax_c = clamp_in(item.ax);
	assign ay_c = clamp_in(item.ay);
	assign bx_c = clamp_in(item.bx);
	assign by_c = clamp_in(item.by);
	assign cx_c = clamp_in(item.cx);
	assign cy_c = clamp_in(item.cy);

	assign ra_x = item.relative ? sat_add(cur_x_q, ax_c) : ax_c;
	assign ra_y = item.relative ? sat_add(cur_y_q, ay_c) : ay_c;
	assign rb_x = item.relative ? sat_add(cur_x_q, bx_c) : bx_c;
	assign rb_y = item.relative ? sat_add(cur_y_q, by_c) : by_c;
	assign rc_x = item.relative ? sat_add(cur_x_q, cx_c) : cx_c;
	assign rc_y = item.relative ? sat_add(cur_y_q, cy_c) : cy_c;

	// reflection of the kept control point about the current point
	assign rf_x = sat_add(cur_x_q, sat_sub(cur_x_q, ctrl_x_q));
	assign rf_y = sat_add(cur_y_q, sat_sub(cur_y_q, ctrl_y_q));

	// relative h/v offsets add up over the groups of one command
	assign acc_new = sat_add(item.first_group ? coord_t'(0) : axis_q, ax_c);
	assign h_x     = item.relative ? sat_add(cur_x_q, acc_new) : ax_c;
	assign v_y     = item.relative ? sat_add(cur_y_q, acc_new) : ax_c;

	always_comb begin
		n_cur_x     = cur_x_q;
		n_cur_y     = cur_y_q;
		n_start_x   = start_x_q;
		n_start_y   = start_y_q;
		n_ctrl_x    = ctrl_x_q;
		n_ctrl_y    = ctrl_y_q;
		n_axis      = axis_q;
		n_last_kind = last_kind_q;
		p0 = '0;
		p1 = '0;
		p2 = '0;
		p3 = '0;
		p4 = '0;
		p5 = '0;
		kind = SEG_LINE;
		emit = 1'b0;
		if (!item.discard) begin
			unique case (item.cmd) inside
				CMD_MOVE, CMD_LINE: begin
					p0 = ra_x;
					p1 = ra_y;
					emit = 1'b1;
					if (item.cmd == CMD_MOVE && item.first_group) begin
						kind = SEG_MOVE;
						n_start_x = ra_x;
						n_start_y = ra_y;
					end
					n_cur_x = ra_x;
					n_cur_y = ra_y;
					n_last_kind = KIND_NONE;
				end
				CMD_HORIZ, CMD_VERT: begin
					if (item.relative) begin
						n_axis = acc_new;
					end
					if (item.last_group) begin
						p0 = (item.cmd == CMD_HORIZ) ? h_x : cur_x_q;
						p1 = (item.cmd == CMD_VERT) ? v_y : cur_y_q;
						emit = 1'b1;
						n_cur_x = p0;
						n_cur_y = p1;
						n_last_kind = KIND_NONE;
					end
				end
				CMD_QUAD: begin
					p0 = ra_x;
					p1 = ra_y;
					p2 = rb_x;
					p3 = rb_y;
					kind = SEG_QUAD;
					emit = 1'b1;
					n_ctrl_x = ra_x;
					n_ctrl_y = ra_y;
					n_cur_x = rb_x;
					n_cur_y = rb_y;
					n_last_kind = KIND_QUAD;
				end
				CMD_CUBIC: begin
					p0 = ra_x;
					p1 = ra_y;
					p2 = rb_x;
					p3 = rb_y;
					p4 = rc_x;
					p5 = rc_y;
					kind = SEG_CUBIC;
					emit = 1'b1;
					n_ctrl_x = rb_x;
					n_ctrl_y = rb_y;
					n_cur_x = rc_x;
					n_cur_y = rc_y;
					n_last_kind = KIND_CUBIC;
				end
				CMD_SQUAD: begin
					p0 = (last_kind_q == KIND_QUAD) ? rf_x : cur_x_q;
					p1 = (last_kind_q == KIND_QUAD) ? rf_y : cur_y_q;
					p2 = ra_x;
					p3 = ra_y;
					kind = SEG_QUAD;
					emit = 1'b1;
					n_ctrl_x = p0;
					n_ctrl_y = p1;
					n_cur_x = ra_x;
					n_cur_y = ra_y;
					n_last_kind = KIND_QUAD;
				end
				CMD_SCUBIC: begin
					p0 = (last_kind_q == KIND_CUBIC) ? rf_x : cur_x_q;
					p1 = (last_kind_q == KIND_CUBIC) ? rf_y : cur_y_q;
					p2 = ra_x;
					p3 = ra_y;
					p4 = rb_x;
					p5 = rb_y;
					kind = SEG_CUBIC;
					emit = 1'b1;
					n_ctrl_x = ra_x;
					n_ctrl_y = ra_y;
					n_cur_x = rb_x;
					n_cur_y = rb_y;
					n_last_kind = KIND_CUBIC;
				end
				CMD_CLOSE: begin
					kind = SEG_CLOSE;
					emit = 1'b1;
					n_cur_x = start_x_q;
					n_cur_y = start_y_q;
					n_last_kind = KIND_NONE;
				end
				default: begin
					// unused command codes are ignored
					emit = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		res.emit         = emit;
		res.seg.seg_kind = kind;
		res.seg.p1x      = to_port(p0);
		res.seg.p1y      = to_port(p1);
		res.seg.p2x      = to_port(p2);
		res.seg.p2y      = to_port(p3);
		res.seg.p3x      = to_port(p4);
		res.seg.p3y      = to_port(p5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			start_x_q   <= '0;
			start_y_q   <= '0;
			ctrl_x_q    <= '0;
			ctrl_y_q    <= '0;
			axis_q      <= '0;
			last_kind_q <= KIND_NONE;
		end else if (take) begin
			cur_x_q     <= n_cur_x;
			cur_y_q     <= n_cur_y;
			start_x_q   <= n_start_x;
			start_y_q   <= n_start_y;
			ctrl_x_q    <= n_ctrl_x;
			ctrl_y_q    <= n_ctrl_y;
			axis_q      <= n_axis;
			last_kind_q <= n_last_kind;
		end
	end
endmodule
`default_nettype wire

/* design/psg_out_reg.sv */
// result register driving the segment channel
// depends on psg_pkg and psg_seg_if
`default_nettype none
module psg_out_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  psg_pkg::seg_item_t  seg_in,
	output logic                free,
	psg_seg_if.source           seg
);
	import psg_pkg::*;

	seg_item_t hold_q;

	// the register can take a new result when empty or being drained
	assign free = !seg.valid || seg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg.valid <= 1'b0;
		end else if (free) begin
			seg.valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			hold_q <= seg_in;
		end
	end

	assign seg.seg_kind = hold_q.seg_kind;
	assign seg.p1x      = hold_q.p1x;
	assign seg.p1y      = hold_q.p1y;
	assign seg.p2x      = hold_q.p2x;
	assign seg.p2y      = hold_q.p2y;
	assign seg.p3x      = hold_q.p3x;
	assign seg.p3y      = hold_q.p3y;
endmodule
`default_nettype wire

/* design/path_command_to_segments.sv */
// channel  dir  payload
// path     in   cmd, relative, first_group, last_group, discard, ax..cy
// seg      out  seg_kind, p1x..p3y
//
// one group per cycle unless seg stalls; group and segment each get a register
// psg_exec feeds back the current point, so each group sees the last one's state
// reset clears the current point, subpath start, control point and h/v sum
// a stalled seg channel holds the staged group, and path.ready drops
// groups that make no segment still pass at one per cycle while u_out is free
// top level: input register, path state and segment logic, result register
// depends on psg_pkg, psg_cmd_if, psg_seg_if, module files and assert header
`default_nettype none
`include "path_command_to_segments_assert.svh"
module path_command_to_segments #(
	parameter int unsigned COORD_WIDTH = psg_pkg::COORD_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	psg_cmd_if.sink   path,
	psg_seg_if.source seg
);
	import psg_pkg::*;

	logic      valid_s1;
	cmd_item_t item_s1;
	exec_res_t res;
	logic      out_free;
	logic      take;
	logic      load;

	assign take = valid_s1 && out_free;
	assign load = take && res.emit;

	psg_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.path     (path),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	psg_exec #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item_s1),
		.res    (res)
	);

	psg_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.seg_in (res.seg),
		.free   (out_free),
		.seg    (seg)
	);

	`PSG_ASSERT_IMPLY(a_new_seg_from_item, clk, arst_n, $rose(seg.valid), $past(take && !item_s1.discard))
	`PSG_ASSERT_NEXT(a_drain_empties, clk, arst_n, seg.valid && seg.ready && !load, !seg.valid)
	`PSG_ASSERT_IMPLY(a_close_no_points, clk, arst_n, seg.valid && seg.seg_kind == SEG_CLOSE, seg.p1x == 0 && seg.p1y == 0 && seg.p2x == 0 && seg.p3y == 0)
	`PSG_ASSERT_IMPLY(a_stage_hold, clk, arst_n, valid_s1 && !out_free, !path.ready)
endmodule
`default_nettype wire

/* tb/segment_checker.sv */
`timescale 1ns / 100ps
// checker for the path command block: tracks the pen, predicts each segment and compares
// depends on psg_pkg, psg_cmd_if and psg_seg_if
module segment_checker (
	input  logic clk,
	input  logic arst_n,
	psg_cmd_if   path,
	psg_seg_if   seg,
	output int   mismatches,
	output int   segs_due_count,
	output int   segs_seen
);
	import psg_pkg::*;

	localparam logic signed [31:0] C_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] C_MIN = 32'sh80000000;

	// pen position, subpath start, kept control point and h/v running sum
	logic signed [31:0] pen_x, pen_y, sub_x, sub_y, knot_x, knot_y, axis_sum;
	curve_kind_t        prior_curve;
	seg_item_t          segs_due[$];

	function automatic logic signed [31:0] sat_sum(logic signed [31:0] a, logic signed [31:0] b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > longint'(C_MAX))
			return C_MAX;
		if (s < longint'(C_MIN))
			return C_MIN;
		return s[31:0];
	endfunction

	function automatic logic signed [31:0] sat_diff(logic signed [31:0] a, logic signed [31:0] b);
		longint s;
		s = longint'(a) - longint'(b);
		if (s > longint'(C_MAX))
			return C_MAX;
		if (s < longint'(C_MIN))
			return C_MIN;
		return s[31:0];
	endfunction

	function automatic logic signed [31:0] place(bit rel, logic signed [31:0] base,
		logic signed [31:0] v);
		return rel ? sat_sum(base, v) : v;
	endfunction

	task automatic trace_path(input cmd_item_t it);
		seg_item_t s;
		bit        emit;
		s = '0;
		emit = 1'b1;
		if (it.discard) begin
			emit = 1'b0;
		end else begin
			case (it.cmd)
				CMD_MOVE, CMD_LINE: begin
					s.p1x = place(it.relative, pen_x, it.ax);
					s.p1y = place(it.relative, pen_y, it.ay);
					// only the first pair of a move starts a subpath
					if (it.cmd == CMD_MOVE && it.first_group) begin
						s.seg_kind = SEG_MOVE;
						sub_x = s.p1x;
						sub_y = s.p1y;
					end else begin
						s.seg_kind = SEG_LINE;
					end
					pen_x = s.p1x;
					pen_y = s.p1y;
					prior_curve = KIND_NONE;
				end
				CMD_HORIZ, CMD_VERT: begin
					if (it.relative) begin
						if (it.first_group)
							axis_sum = '0;
						axis_sum = sat_sum(axis_sum, it.ax);
					end
					if (!it.last_group) begin
						emit = 1'b0;
					end else begin
						s.seg_kind = SEG_LINE;
						s.p1x = pen_x;
						s.p1y = pen_y;
						if (it.cmd == CMD_HORIZ)
							s.p1x = it.relative ? sat_sum(pen_x, axis_sum) : it.ax;
						else
							s.p1y = it.relative ? sat_sum(pen_y, axis_sum) : it.ax;
						pen_x = s.p1x;
						pen_y = s.p1y;
						prior_curve = KIND_NONE;
					end
				end
				CMD_QUAD: begin
					s.seg_kind = SEG_QUAD;
					s.p1x = place(it.relative, pen_x, it.ax);
					s.p1y = place(it.relative, pen_y, it.ay);
					s.p2x = place(it.relative, pen_x, it.bx);
					s.p2y = place(it.relative, pen_y, it.by);
					knot_x = s.p1x;
					knot_y = s.p1y;
					pen_x = s.p2x;
					pen_y = s.p2y;
					prior_curve = KIND_QUAD;
				end
				CMD_CUBIC: begin
					s.seg_kind = SEG_CUBIC;
					s.p1x = place(it.relative, pen_x, it.ax);
					s.p1y = place(it.relative, pen_y, it.ay);
					s.p2x = place(it.relative, pen_x, it.bx);
					s.p2y = place(it.relative, pen_y, it.by);
					s.p3x = place(it.relative, pen_x, it.cx);
					s.p3y = place(it.relative, pen_y, it.cy);
					knot_x = s.p2x;
					knot_y = s.p2y;
					pen_x = s.p3x;
					pen_y = s.p3y;
					prior_curve = KIND_CUBIC;
				end
				CMD_SQUAD: begin
					s.seg_kind = SEG_QUAD;
					// reflect only after a quadratic, else the pen itself
					if (prior_curve == KIND_QUAD) begin
						s.p1x = sat_sum(pen_x, sat_diff(pen_x, knot_x));
						s.p1y = sat_sum(pen_y, sat_diff(pen_y, knot_y));
					end else begin
						s.p1x = pen_x;
						s.p1y = pen_y;
					end
					s.p2x = place(it.relative, pen_x, it.ax);
					s.p2y = place(it.relative, pen_y, it.ay);
					knot_x = s.p1x;
					knot_y = s.p1y;
					pen_x = s.p2x;
					pen_y = s.p2y;
					prior_curve = KIND_QUAD;
				end
				CMD_SCUBIC: begin
					s.seg_kind = SEG_CUBIC;
					if (prior_curve == KIND_CUBIC) begin
						s.p1x = sat_sum(pen_x, sat_diff(pen_x, knot_x));
						s.p1y = sat_sum(pen_y, sat_diff(pen_y, knot_y));
					end else begin
						s.p1x = pen_x;
						s.p1y = pen_y;
					end
					s.p2x = place(it.relative, pen_x, it.ax);
					s.p2y = place(it.relative, pen_y, it.ay);
					s.p3x = place(it.relative, pen_x, it.bx);
					s.p3y = place(it.relative, pen_y, it.by);
					knot_x = s.p2x;
					knot_y = s.p2y;
					pen_x = s.p3x;
					pen_y = s.p3y;
					prior_curve = KIND_CUBIC;
				end
				CMD_CLOSE: begin
					s.seg_kind = SEG_CLOSE;
					pen_x = sub_x;
					pen_y = sub_y;
					prior_curve = KIND_NONE;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
		if (emit)
			segs_due.insert(segs_due.size(), s);
	endtask

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < 40)
			$display("segment %0d: %s got %h want %h", segs_seen, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			flag_mismatch(name, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		seg_item_t got, want;
		if (!arst_n) begin
			pen_x = '0;
			pen_y = '0;
			sub_x = '0;
			sub_y = '0;
			knot_x = '0;
			knot_y = '0;
			axis_sum = '0;
			prior_curve = KIND_NONE;
			segs_due.delete();
			segs_due_count = 0;
			segs_seen = 0;
			mismatches = 0;
		end else begin
			if (seg.valid && seg.ready) begin
				got.seg_kind = seg.seg_kind;
				got.p1x = seg.p1x;
				got.p1y = seg.p1y;
				got.p2x = seg.p2x;
				got.p2y = seg.p2y;
				got.p3x = seg.p3x;
				got.p3y = seg.p3y;
				if (segs_due.size() == 0) begin
					flag_mismatch("segment with none expected, kind", 32'(got.seg_kind),
						'0);
				end else begin
					want = segs_due.pop_front();
					check_field("seg_kind", 32'(got.seg_kind), 32'(want.seg_kind));
					check_field("p1x", got.p1x, want.p1x);
					check_field("p1y", got.p1y, want.p1y);
					check_field("p2x", got.p2x, want.p2x);
					check_field("p2y", got.p2y, want.p2y);
					check_field("p3x", got.p3x, want.p3x);
					check_field("p3y", got.p3y, want.p3y);
				end
				segs_seen++;
			end
			if (path.valid && path.ready) begin
				cmd_item_t it;
				it.cmd = path.cmd;
				it.relative = path.relative;
				it.first_group = path.first_group;
				it.last_group = path.last_group;
				it.discard = path.discard;
				it.ax = path.ax;
				it.ay = path.ay;
				it.bx = path.bx;
				it.by = path.by;
				it.cx = path.cx;
				it.cy = path.cy;
				trace_path(it);
			end
			segs_due_count = segs_due.size();
		end
	end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// top of the path command testbench: clock, reset, command stimulus and verdict
// depends on psg_pkg, both channel interfaces, the block and segment_checker
module testbench;
	import psg_pkg::*;

	localparam int ITEMS_WANTED = 1300;
	localparam int CYCLE_LIMIT  = 100000;
	localparam logic signed [31:0] C_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] C_MIN = 32'sh80000000;
	localparam logic signed [31:0] ONE   = 32'sh00010000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	int   cycles = 0;
	int   groups_sent = 0;
	int   groups_ignored = 0;
	int   mismatches, segs_due, segs_seen;

	psg_cmd_if path_ch();
	psg_seg_if seg_ch();

	path_command_to_segments DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.path   (path_ch),
		.seg    (seg_ch)
	);

	segment_checker CHK (
		.clk            (clk),
		.arst_n         (arst_n),
		.path           (path_ch),
		.seg            (seg_ch),
		.mismatches     (mismatches),
		.segs_due_count (segs_due),
		.segs_seen      (segs_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// segment sink stalls at random except in the calm stretch
	always @(negedge clk)
		seg_ch.ready <= calm || $urandom_range(99) >= 18;

	function automatic cmd_item_t grp(logic [3:0] c, bit rel, bit first, bit last,
		logic signed [31:0] ax = 0, logic signed [31:0] ay = 0,
		logic signed [31:0] bx = 0, logic signed [31:0] by = 0,
		logic signed [31:0] cx = 0, logic signed [31:0] cy = 0);
		cmd_item_t it;
		it.cmd = c;
		it.relative = rel;
		it.first_group = first;
		it.last_group = last;
		it.discard = 1'b0;
		it.ax = ax;
		it.ay = ay;
		it.bx = bx;
		it.by = by;
		it.cx = cx;
		it.cy = cy;
		return it;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(15))
			0: return C_MAX;
			1: return C_MIN;
			2: return C_MAX - $urandom_range(255);
			3: return C_MIN + $urandom_range(255);
			4, 5, 6: return $urandom;
			default: return $signed($urandom_range(32'h003fffff)) - 32'sh00200000;
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_group(input cmd_item_t it);
		bit taken;
		while (!calm && $urandom_range(99) < 18) begin
			path_ch.valid <= 1'b0;
			@(negedge clk);
		end
		path_ch.valid <= 1'b1;
		path_ch.cmd <= it.cmd;
		path_ch.relative <= it.relative;
		path_ch.first_group <= it.first_group;
		path_ch.last_group <= it.last_group;
		path_ch.discard <= it.discard;
		path_ch.ax <= it.ax;
		path_ch.ay <= it.ay;
		path_ch.bx <= it.bx;
		path_ch.by <= it.by;
		path_ch.cx <= it.cx;
		path_ch.cy <= it.cy;
		do begin
			@(posedge clk);
			taken = path_ch.ready;
			@(negedge clk);
		end while (!taken);
		if (it.discard || it.cmd > CMD_CLOSE)
			groups_ignored++;
		else
			groups_sent++;
	endtask

	// one well-formed command with random content, or a malformed one flagged discard
	task automatic send_command(input bit spoil);
		cmd_item_t it;
		logic [3:0] c;
		bit         rel;
		int         n;
		c = 4'($urandom_range(int'(CMD_CLOSE)));
		rel = 1'($urandom_range(1));
		if (c == CMD_CLOSE)
			n = 1;
		else if (c == CMD_HORIZ || c == CMD_VERT)
			n = $urandom_range(1, 4);
		else
			n = $urandom_range(1, 3);
		for (int g = 0; g < n; g++) begin
			it = grp(c, rel, g == 0, g == n - 1, rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_coord(), rand_coord());
			it.discard = spoil;
			send_group(it);
		end
	endtask

	initial begin
		cmd_item_t it;
		int        roll;
		path_ch.valid = 1'b0;
		path_ch.cmd = '0;
		path_ch.relative = 1'b0;
		path_ch.first_group = 1'b0;
		path_ch.last_group = 1'b0;
		path_ch.discard = 1'b0;
		path_ch.ax = '0;
		path_ch.ay = '0;
		path_ch.bx = '0;
		path_ch.by = '0;
		path_ch.cx = '0;
		path_ch.cy = '0;
		seg_ch.ready = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// smooth curves straight after reset take the pen itself as first control point
		send_group(grp(CMD_SQUAD, 0, 1, 1, 10 * ONE, 20 * ONE));
		send_group(grp(CMD_SCUBIC, 1, 1, 1, ONE, -ONE, 3 * ONE, 2 * ONE));
		// extremes and saturating relative line
		send_group(grp(CMD_MOVE, 0, 1, 1, C_MAX, C_MIN));
		send_group(grp(CMD_LINE, 1, 1, 1, ONE, -ONE));
		// absolute move with extra pairs turning into lines
		send_group(grp(CMD_MOVE, 0, 1, 0, C_MIN, C_MAX));
		send_group(grp(CMD_MOVE, 0, 0, 0, 5 * ONE, 6 * ONE));
		send_group(grp(CMD_MOVE, 0, 0, 1, -7 * ONE, 8 * ONE));
		// absolute horizontal, last value wins
		send_group(grp(CMD_HORIZ, 0, 1, 0, 100 * ONE));
		send_group(grp(CMD_HORIZ, 0, 0, 0, -3 * ONE));
		send_group(grp(CMD_HORIZ, 0, 0, 1, 42 * ONE));
		// relative vertical sum saturating
		send_group(grp(CMD_VERT, 1, 1, 0, C_MAX));
		send_group(grp(CMD_VERT, 1, 0, 0, C_MAX));
		send_group(grp(CMD_VERT, 1, 0, 1, -ONE));
		// relative horizontal without a first group keeps the old sum
		send_group(grp(CMD_HORIZ, 1, 0, 1, 2 * ONE));
		// quadratic then reflections that saturate
		send_group(grp(CMD_QUAD, 0, 1, 1, C_MAX, C_MAX, C_MIN, C_MIN));
		send_group(grp(CMD_SQUAD, 1, 1, 1, ONE, ONE));
		send_group(grp(CMD_CUBIC, 1, 1, 1, C_MAX, C_MIN, -ONE, ONE, C_MIN, C_MAX));
		send_group(grp(CMD_SCUBIC, 0, 1, 1, C_MIN, C_MAX, 9 * ONE, -9 * ONE));
		send_group(grp(CMD_SCUBIC, 1, 1, 1, ONE, 2 * ONE, -ONE, -2 * ONE));
		// smooth quadratic after a cubic has nothing to reflect
		send_group(grp(CMD_SQUAD, 0, 1, 1, 4 * ONE, 4 * ONE));
		send_group(grp(CMD_CLOSE, 0, 1, 1));
		it = grp(CMD_LINE, 1, 1, 1, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
		it.discard = 1'b1;
		send_group(it);
		send_group(grp(4'd9, 1, 1, 1, C_MAX, C_MAX));
		send_group(grp(4'd15, 0, 0, 0, C_MIN, C_MIN));
		send_group(grp(CMD_CLOSE, 1, 1, 1));
		send_group(grp(CMD_MOVE, 1, 1, 1, -ONE, ONE));

		while (groups_sent < ITEMS_WANTED) begin
			calm = groups_sent >= 500 && groups_sent < 700;
			roll = $urandom_range(99);
			if (roll < 8) begin
				// noise: any code, any flags
				it = grp(4'($urandom_range(15)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'($urandom_range(1)), rand_coord(),
					rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord());
				it.discard = $urandom_range(3) == 0;
				send_group(it);
			end else begin
				send_command(roll < 14);
			end
		end
		calm = 1'b0;
		path_ch.valid <= 1'b0;

		while (segs_due != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("covered %0d coordinate groups of all nine commands, %0d ignored ones",
			groups_sent, groups_ignored);
		$display("%0d segments compared, %0d mismatches", segs_seen, mismatches);
		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule

/* path_command_to_segments.f */
+incdir+design
design/psg_pkg.sv
design/psg_cmd_if.sv
design/psg_seg_if.sv
design/psg_in_reg.sv
design/psg_exec.sv
design/psg_out_reg.sv
design/path_command_to_segments.sv
tb/segment_checker.sv
tb/testbench.sv
